[rtl/cpu_ibd_pkg.sv]
// Shared types, codes and opcode classification for the instruction boundary decoder.
package cpu_ibd_pkg;

  localparam int unsigned AddrW    = 16;
  localparam int unsigned CountW   = 17;
  localparam int unsigned CfgDataW = 17;
  localparam int unsigned CfgIdxW  = 1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegDataStart = 1'd0;
  localparam logic [CfgIdxW-1:0] RegDataCount = 1'd1;

  // Record status codes
  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StTrunc = 2'd1;
  localparam logic [1:0] StOver  = 2'd2;

  // Operand phase codes
  localparam logic [1:0] PhOpcode = 2'd0;
  localparam logic [1:0] PhLow    = 2'd1;
  localparam logic [1:0] PhHigh   = 2'd2;

  localparam logic [AddrW-1:0] LastAddr = 16'hffff;

  typedef enum logic [1:0] {
    KindNone  = 2'd0,
    KindByte  = 2'd1,
    KindWord  = 2'd2,
    KindUndoc = 2'd3
  } op_kind_e;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [AddrW-1:0] instr_address;
    logic [7:0]       opcode;
    logic [1:0]       length;
    logic [1:0]       operand_kind;
    logic [15:0]      operand_value;
    logic             is_data;
    logic [1:0]       status;
  } out_beat_t;

  // Documented 8080 opcode table, folded into a few bit patterns.
  function automatic op_kind_e classify(input logic [7:0] op);
    op_kind_e k;
    k = KindNone;
    if (((op & 8'hc7) == 8'h00 && op != 8'h00) ||
        (op inside {8'hcb, 8'hd9, 8'hdd, 8'hed, 8'hfd})) begin
      k = KindUndoc;
    end else if ((op & 8'hc7) == 8'h06 || (op & 8'hc7) == 8'hc6 ||
                 (op inside {8'hd3, 8'hdb})) begin
      k = KindByte;
    end else if ((op & 8'hcf) == 8'h01 ||
                 (op inside {8'h22, 8'h2a, 8'h32, 8'h3a, 8'hc3, 8'hcd}) ||
                 (op & 8'hc7) == 8'hc2 || (op & 8'hc7) == 8'hc4) begin
      k = KindWord;
    end
    return k;
  endfunction

endpackage

[rtl/cpu8080_instruction_boundary_decoder_unit.sv]
// Top level: splits an 8080 code image into instruction records, one byte per beat.
//
// The block takes one code byte per clock cycle while the output is not stalled,
// starting at address 0. A byte is held in the input register, where the opcode table
// lookup, the forced-data region compare and the operand phase counter decide its fate,
// and the finished record lands in the output register. Opcode bytes of multi-byte
// instructions and the first operand byte of a word give no record; the record comes
// with the last operand byte, or early with truncated or overrun status. After
// last_byte, after an overrun, or past address 0xffff, beats are still taken but
// dropped. The user must write the forced-data region through the configuration port
// only while no beat is in flight; the block itself does not enforce this.
module cpu8080_instruction_boundary_decoder_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [cpu_ibd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [cpu_ibd_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  cpu_ibd_pkg::in_beat_t           in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output cpu_ibd_pkg::out_beat_t          out_data_o
);

  // configuration
  logic [cpu_ibd_pkg::AddrW-1:0]  region_start_q;
  logic [cpu_ibd_pkg::CountW-1:0] region_count_q;

  // input stage
  logic                  stage_valid_q;
  cpu_ibd_pkg::in_beat_t stage_beat_q;

  // decode state
  logic [cpu_ibd_pkg::AddrW:0]   addr_q, addr_d;
  logic [1:0]                    phase_q, phase_d;
  logic [7:0]                    held_op_q, held_op_d;
  logic [7:0]                    held_low_q, held_low_d;
  logic [cpu_ibd_pkg::AddrW-1:0] held_start_q, held_start_d;
  logic                          stopped_q, stopped_d;

  // output stage
  logic                   out_valid_q;
  cpu_ibd_pkg::out_beat_t out_beat_q;

  logic                          out_free;
  logic                          stage_fire;
  logic                          live;
  logic                          rec_valid;
  cpu_ibd_pkg::out_beat_t        rec;
  logic [cpu_ibd_pkg::AddrW-1:0] a;
  logic [7:0]                    b;
  cpu_ibd_pkg::op_kind_e         kind_b;
  cpu_ibd_pkg::op_kind_e         kind_h;
  logic [cpu_ibd_pkg::AddrW+1:0] region_end;
  logic                          in_region;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign stage_fire = stage_valid_q && out_free;
  assign in_stall_o = stage_valid_q && !out_free;
  assign live       = stage_fire && !stopped_q && !addr_q[cpu_ibd_pkg::AddrW];

  assign a      = addr_q[cpu_ibd_pkg::AddrW-1:0];
  assign b      = stage_beat_q.code_byte;
  assign kind_b = cpu_ibd_pkg::classify(b);
  assign kind_h = cpu_ibd_pkg::classify(held_op_q);

  assign region_end = {2'b00, region_start_q} + {1'b0, region_count_q};
  assign in_region  = (region_count_q != '0) && (a >= region_start_q) &&
                      ({2'b00, a} < region_end);

  always_comb begin
    addr_d       = addr_q;
    phase_d      = phase_q;
    held_op_d    = held_op_q;
    held_low_d   = held_low_q;
    held_start_d = held_start_q;
    stopped_d    = stopped_q;
    rec_valid    = 1'b0;
    rec          = '0;
    if (live) begin
      addr_d = addr_q + 1'b1;
      if (stage_beat_q.last_byte) begin
        stopped_d = 1'b1;
      end
      phase_d = cpu_ibd_pkg::PhOpcode;
      case (phase_q)
        cpu_ibd_pkg::PhLow: begin
          rec_valid              = 1'b1;
          rec.instr_address      = held_start_q;
          rec.opcode             = held_op_q;
          rec.operand_value      = {8'h00, b};
          if (kind_h == cpu_ibd_pkg::KindByte) begin
            rec.length       = 2'd2;
            rec.operand_kind = cpu_ibd_pkg::KindByte;
            rec.status       = cpu_ibd_pkg::StOk;
          end else begin
            rec.length       = 2'd3;
            rec.operand_kind = cpu_ibd_pkg::KindWord;
            if (a == cpu_ibd_pkg::LastAddr) begin
              stopped_d  = 1'b1;
              rec.status = cpu_ibd_pkg::StOver;
            end else if (stage_beat_q.last_byte) begin
              rec.status = cpu_ibd_pkg::StTrunc;
            end else begin
              // hold the low byte and wait for the high one
              rec_valid  = 1'b0;
              held_low_d = b;
              phase_d    = cpu_ibd_pkg::PhHigh;
            end
          end
        end
        cpu_ibd_pkg::PhHigh: begin
          rec_valid         = 1'b1;
          rec.instr_address = held_start_q;
          rec.opcode        = held_op_q;
          rec.length        = 2'd3;
          rec.operand_kind  = cpu_ibd_pkg::KindWord;
          rec.operand_value = {b, held_low_q};
          rec.status        = cpu_ibd_pkg::StOk;
        end
        default: begin
          rec_valid         = 1'b1;
          rec.instr_address = a;
          rec.opcode        = b;
          rec.length        = 2'd1;
          rec.operand_kind  = cpu_ibd_pkg::KindNone;
          rec.status        = cpu_ibd_pkg::StOk;
          if (in_region || kind_b == cpu_ibd_pkg::KindUndoc) begin
            rec.is_data = 1'b1;
          end else if (kind_b != cpu_ibd_pkg::KindNone) begin
            held_op_d        = b;
            held_start_d     = a;
            rec.length       = 2'(kind_b) + 2'd1;
            rec.operand_kind = 2'(kind_b);
            if (a == cpu_ibd_pkg::LastAddr) begin
              stopped_d  = 1'b1;
              rec.status = cpu_ibd_pkg::StOver;
            end else if (stage_beat_q.last_byte) begin
              rec.status = cpu_ibd_pkg::StTrunc;
            end else begin
              rec_valid = 1'b0;
              phase_d   = cpu_ibd_pkg::PhLow;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_start_q <= '0;
      region_count_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        cpu_ibd_pkg::RegDataStart: region_start_q <= cfg_data_i[cpu_ibd_pkg::AddrW-1:0];
        cpu_ibd_pkg::RegDataCount: region_count_q <= cfg_data_i[cpu_ibd_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
      out_valid_q   <= 1'b0;
      addr_q        <= '0;
      phase_q       <= cpu_ibd_pkg::PhOpcode;
      stopped_q     <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        stage_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= rec_valid;
      end
      addr_q    <= addr_d;
      phase_q   <= phase_d;
      stopped_q <= stopped_d;
    end
  end

  // payload: no reset
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      stage_beat_q <= in_data_i;
    end
    if (out_free && rec_valid) begin
      out_beat_q <= rec;
    end
    held_op_q    <= held_op_d;
    held_low_q   <= held_low_d;
    held_start_q <= held_start_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_beat_q;

  a_phase_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != 2'd3)
    else $error("operand phase reached an unused code");

  a_len_matches_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.length == out_data_o.operand_kind + 2'd1)
    else $error("record length does not match operand kind");

  a_data_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.is_data |->
      out_data_o.length == 2'd1 && out_data_o.operand_value == '0 &&
      out_data_o.status == cpu_ibd_pkg::StOk)
    else $error("malformed data record");

  a_stop_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stopped_q |=> stopped_q)
    else $error("decoder left the stopped state without reset");

  a_addr_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live |=> addr_q == $past(addr_q) + 1'b1)
    else $error("byte address did not advance on a live beat");

endmodule

[sim/cpu8080_instruction_boundary_decoder_checker.sv]
// Record checker: decodes accepted code bytes and compares the expected records with the output.
module cpu8080_instruction_boundary_decoder_checker
  import cpu_ibd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  in_beat_t           in_data_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  out_beat_t          out_data_i,
  output int                 mismatches_o,
  output int                 records_pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Irregular opcodes of the decode table
  localparam logic [7:0] OpJmp    = 8'hc3;
  localparam logic [7:0] OpCall   = 8'hcd;
  localparam logic [7:0] OpOut    = 8'hd3;
  localparam logic [7:0] OpIn     = 8'hdb;
  localparam logic [7:0] OpAltJmp = 8'hcb;
  localparam logic [7:0] OpAltRet = 8'hd9;

  logic [15:0] region_start = '0;
  logic [16:0] region_count = '0;
  logic [16:0] next_addr    = '0;
  logic [1:0]  op_phase     = PhOpcode;
  logic [7:0]  held_op      = '0;
  logic [7:0]  held_lo      = '0;
  logic [15:0] held_addr    = '0;
  logic        halted       = 1'b0;
  out_beat_t   expected_records [$];
  int          mismatches   = 0;

  // Decode by row (op[7:6]) and column (op[2:0]) of the opcode map.
  function automatic op_kind_e opcode_kind(input logic [7:0] op);
    op_kind_e k;
    k = KindNone;
    case (op[7:6])
      2'b00: begin
        case (op[2:0])
          3'd0: k = (op == 8'h00) ? KindNone : KindUndoc;
          3'd1: k = op[3] ? KindNone : KindWord;
          3'd2: k = op[5] ? KindWord : KindNone;
          3'd6: k = KindByte;
          default: k = KindNone;
        endcase
      end
      2'b11: begin
        case (op[2:0])
          3'd1: k = (op == OpAltRet) ? KindUndoc : KindNone;
          3'd2, 3'd4: k = KindWord;
          3'd3: begin
            if (op == OpJmp) k = KindWord;
            else if (op == OpAltJmp) k = KindUndoc;
            else if (op == OpOut || op == OpIn) k = KindByte;
          end
          3'd5: begin
            if (op == OpCall) k = KindWord;
            else if (op[3]) k = KindUndoc;
          end
          3'd6: k = KindByte;
          default: k = KindNone;
        endcase
      end
      default: k = KindNone;
    endcase
    return k;
  endfunction

  function automatic logic in_data_region(input logic [15:0] a);
    logic [17:0] region_end;
    region_end = {2'b00, region_start} + {1'b0, region_count};
    return (region_count != '0) && (a >= region_start) && ({2'b00, a} < region_end);
  endfunction

  task automatic decode_beat(input in_beat_t beat);
    out_beat_t rec;
    logic      emit;
    op_kind_e  kind;
    logic [15:0] a;
    if (halted || next_addr[16]) return;
    a = next_addr[15:0];
    next_addr = next_addr + 17'd1;
    if (beat.last_byte) halted = 1'b1;
    emit = 1'b0;
    rec = '0;
    case (op_phase)
      PhLow: begin
        kind = opcode_kind(held_op);
        rec.instr_address = held_addr;
        rec.opcode = held_op;
        rec.operand_value = {8'h00, beat.code_byte};
        if (kind == KindByte) begin
          rec.length = 2'd2;
          rec.operand_kind = KindByte;
          emit = 1'b1;
          op_phase = PhOpcode;
        end else if (a == LastAddr || beat.last_byte) begin
          // word cut short: overrun wins over truncation
          rec.length = 2'd3;
          rec.operand_kind = KindWord;
          rec.status = (a == LastAddr) ? StOver : StTrunc;
          if (a == LastAddr) halted = 1'b1;
          emit = 1'b1;
          op_phase = PhOpcode;
        end else begin
          held_lo = beat.code_byte;
          op_phase = PhHigh;
        end
      end
      PhHigh: begin
        rec.instr_address = held_addr;
        rec.opcode = held_op;
        rec.length = 2'd3;
        rec.operand_kind = KindWord;
        rec.operand_value = {beat.code_byte, held_lo};
        emit = 1'b1;
        op_phase = PhOpcode;
      end
      default: begin
        op_phase = PhOpcode;
        kind = opcode_kind(beat.code_byte);
        rec.instr_address = a;
        rec.opcode = beat.code_byte;
        rec.length = 2'd1;
        if (in_data_region(a) || kind == KindUndoc) begin
          rec.is_data = 1'b1;
          emit = 1'b1;
        end else if (kind == KindNone) begin
          emit = 1'b1;
        end else begin
          held_op = beat.code_byte;
          held_addr = a;
          rec.length = 2'(kind) + 2'd1;
          rec.operand_kind = kind;
          if (a == LastAddr) begin
            halted = 1'b1;
            rec.status = StOver;
            emit = 1'b1;
          end else if (beat.last_byte) begin
            rec.status = StTrunc;
            emit = 1'b1;
          end else begin
            op_phase = PhLow;
          end
        end
      end
    endcase
    if (emit) expected_records.push_back(rec);
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_record(input out_beat_t got);
    out_beat_t want;
    if (expected_records.size() == 0) begin
      $display("%0t: record at %0h expected none actual opcode %0h", $time,
               got.instr_address, got.opcode);
      mismatches++;
      return;
    end
    want = expected_records.pop_front();
    check_field("instr_address", want.instr_address, got.instr_address);
    check_field("opcode", 16'(want.opcode), 16'(got.opcode));
    check_field("length", 16'(want.length), 16'(got.length));
    check_field("operand_kind", 16'(want.operand_kind), 16'(got.operand_kind));
    check_field("operand_value", want.operand_value, got.operand_value);
    check_field("is_data", 16'(want.is_data), 16'(got.is_data));
    check_field("status", 16'(want.status), 16'(got.status));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_start = '0;
      region_count = '0;
      next_addr = '0;
      op_phase = PhOpcode;
      held_op = '0;
      held_lo = '0;
      held_addr = '0;
      halted = 1'b0;
      expected_records.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegDataStart: region_start = cfg_data_i[15:0];
          RegDataCount: region_count = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) check_record(out_data_i);
      if (in_valid_i && !in_stall_i) decode_beat(in_data_i);
    end
    mismatches_o <= mismatches;
    records_pending_o <= expected_records.size();
  end

endmodule

[sim/cpu8080_instruction_boundary_decoder_unit_test.sv]
// Testbench top: drives code images and region settings into the decoder and reports the verdict.
module cpu8080_instruction_boundary_decoder_unit_test;
  import cpu_ibd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HalfPeriod   = 2;
  localparam int ResetCycles  = 6;
  localparam int DrainCycles  = 4;
  localparam int TailCycles   = 8;
  localparam int NumPhases    = 8;
  localparam int PhaseBeats   = 118;
  localparam int HoldAt       = 400;
  localparam int HoldCycles   = 300;
  localparam int CalmFrom     = 600;
  localparam int CalmTo       = 750;
  localparam int IgnoredBeats = 10;
  localparam int StallLimit   = 5000;

  localparam logic [7:0] OpNop     = 8'h00;
  localparam logic [7:0] OpLxiB    = 8'h01;
  localparam logic [7:0] OpUndoc08 = 8'h08;
  localparam logic [7:0] OpShld    = 8'h22;
  localparam logic [7:0] OpLda     = 8'h3a;
  localparam logic [7:0] OpMviA    = 8'h3e;
  localparam logic [7:0] OpHlt     = 8'h76;
  localparam logic [7:0] OpJmp     = 8'hc3;
  localparam logic [7:0] OpAdi     = 8'hc6;
  localparam logic [7:0] OpUndocCb = 8'hcb;
  localparam logic [7:0] OpCall    = 8'hcd;
  localparam logic [7:0] OpOut     = 8'hd3;
  localparam logic [7:0] OpUndocD9 = 8'hd9;
  localparam logic [7:0] OpIn      = 8'hdb;
  localparam logic [7:0] OpUndocDd = 8'hdd;
  localparam logic [7:0] OpUndocEd = 8'hed;
  localparam logic [7:0] OpUndocFd = 8'hfd;
  localparam logic [7:0] OpRst7    = 8'hff;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = RegDataStart;
  logic [CfgDataW-1:0] cfg_data  = '0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  in_beat_t            in_beat   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_beat_t           out_record;
  int                  mismatches;
  int                  records_pending;
  int                  beats_sent = 0;
  logic [7:0]          directed_bytes [25];

  always #HalfPeriod clk = ~clk;

  cpu8080_instruction_boundary_decoder_unit u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_beat),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_record)
  );

  cpu8080_instruction_boundary_decoder_checker u_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .in_data_i         (in_beat),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .out_data_i        (out_record),
    .mismatches_o      (mismatches),
    .records_pending_o (records_pending)
  );

  function automatic logic idle_now();
    return !(beats_sent >= CalmFrom && beats_sent < CalmTo) && ($urandom_range(99) < 18);
  endfunction

  function automatic logic [7:0] rand_operand();
    logic [7:0] v;
    case ($urandom_range(3))
      0: v = 8'h00;
      1: v = 8'hff;
      default: v = 8'($urandom_range(255));
    endcase
    return v;
  endfunction

  function automatic logic [7:0] pick_opcode(input op_kind_e kind);
    logic [7:0] op;
    logic [2:0] row;
    row = 3'($urandom_range(7));
    case (kind)
      KindByte: begin
        case ($urandom_range(2))
          0: op = {2'b00, row, 3'd6};
          1: op = {2'b11, row, 3'd6};
          default: op = $urandom_range(1) ? OpOut : OpIn;
        endcase
      end
      KindWord: begin
        case ($urandom_range(4))
          0: op = {2'b00, row[1:0], 4'b0001};
          1: op = {3'b001, row[1:0], 3'b010};
          2: op = {2'b11, row, 3'd2};
          3: op = {2'b11, row, 3'd4};
          default: op = $urandom_range(1) ? OpJmp : OpCall;
        endcase
      end
      KindUndoc: begin
        case ($urandom_range(5))
          0: op = OpUndocCb;
          1: op = OpUndocD9;
          2: op = OpUndocDd;
          3: op = OpUndocEd;
          4: op = OpUndocFd;
          default: op = {2'b00, 3'($urandom_range(7, 1)), 3'd0};
        endcase
      end
      default: begin
        case ($urandom_range(3))
          0: op = 8'h40 + 8'($urandom_range(63));
          1: op = 8'h80 + 8'($urandom_range(63));
          2: op = {2'b00, row, ($urandom_range(1) ? 3'd3 : 3'd7)};
          default: op = {2'b11, row, ($urandom_range(1) ? 3'd0 : 3'd7)};
        endcase
      end
    endcase
    return op;
  endfunction

  // Offer one beat, holding it until the block takes it.
  task automatic send_beat(input logic [7:0] b, input logic last);
    while (idle_now()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat <= '{code_byte: b, last_byte: last};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_instr(input op_kind_e kind);
    send_beat(pick_opcode(kind), 1'b0);
    if (kind == KindByte) begin
      send_beat(rand_operand(), 1'b0);
    end else if (kind == KindWord) begin
      send_beat(rand_operand(), 1'b0);
      send_beat(rand_operand(), 1'b0);
    end
  endtask

  task automatic send_random_item();
    int r;
    r = $urandom_range(99);
    if (r < 8) begin
      send_beat(8'($urandom_range(255)), 1'b0);
    end else if (r < 16) begin
      send_instr(KindUndoc);
    end else begin
      case (r % 3)
        0: send_instr(KindNone);
        1: send_instr(KindByte);
        default: send_instr(KindWord);
      endcase
    end
  endtask

  // Drop valid, wait for every expected record, then let the pipeline empty.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (records_pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_region(input logic [15:0] start, input logic [16:0] count);
    cfg_we <= 1'b1;
    cfg_index <= RegDataStart;
    cfg_data <= {1'b0, start};
    @(posedge clk);
    cfg_index <= RegDataCount;
    cfg_data <= count;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Output side: random stalls, one long hold-off, none in the calm window.
  initial begin
    int hold_left;
    logic hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (!hold_done && beats_sent >= HoldAt) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
        out_stall <= 1'b1;
      end else begin
        out_stall <= idle_now();
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < StallLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("cpu8080_instruction_boundary_decoder_unit: mismatch");
    $finish;
  end

  initial begin
    int unsigned variant;
    int phase_base;
    logic [15:0] here;
    directed_bytes = '{OpNop, OpRst7, OpUndoc08, OpJmp, 8'h00, 8'hff, OpCall, OpMviA, 8'hff,
                       OpIn, 8'h00, OpLxiB, 8'h34, 8'h12, OpUndocFd, OpUndocCb, OpHlt, OpLda,
                       8'hff, 8'hff, OpAdi, 8'h80, OpShld, 8'h00, 8'h00};
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Region over the operands of the jump and the call opcode after it.
    write_region(16'd4, 17'd3);
    foreach (directed_bytes[i]) send_beat(directed_bytes[i], 1'b0);

    for (int p = 0; p < NumPhases; p++) begin
      wait_drained();
      here = 16'(beats_sent);
      case (p)
        0: write_region(16'h0000, 17'h00000);
        1: write_region(16'h0000, 17'h10000);
        2: write_region(here + 16'($urandom_range(30)), 17'($urandom_range(40, 1)));
        3: write_region(LastAddr, 17'h10000);
        4: write_region(here + 16'($urandom_range(100)), 17'h10000);
        5: write_region(here + 16'($urandom_range(10)), 17'd1);
        6: write_region(16'($urandom_range(16'hffff)), 17'($urandom_range(17'h10000)));
        default: write_region(here + 16'($urandom_range(20)), 17'($urandom_range(60, 1)));
      endcase
      phase_base = beats_sent;
      while (beats_sent - phase_base < PhaseBeats) send_random_item();
    end

    // Finish the image with a cut-short or a complete last instruction.
    variant = $urandom_range(3);
    wait_drained();
    write_region(16'h0000, 17'h00000);
    send_beat(OpNop, 1'b0);
    send_beat(OpNop, 1'b0);
    case (variant)
      0: send_beat(pick_opcode(KindWord), 1'b1);
      1: begin
        send_beat(pick_opcode(KindWord), 1'b0);
        send_beat(rand_operand(), 1'b1);
      end
      2: send_beat(pick_opcode(KindByte), 1'b1);
      default: send_beat(pick_opcode(KindNone), 1'b1);
    endcase
    repeat (IgnoredBeats) send_beat(8'($urandom_range(255)), 1'($urandom_range(1)));

    wait_drained();
    repeat (TailCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("cpu8080_instruction_boundary_decoder_unit: match");
    end else begin
      $display("cpu8080_instruction_boundary_decoder_unit: mismatch");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/cpu_ibd_pkg.sv
rtl/cpu8080_instruction_boundary_decoder_unit.sv
sim/cpu8080_instruction_boundary_decoder_checker.sv
sim/cpu8080_instruction_boundary_decoder_unit_test.sv
